// ===== hw/rtl/emm_pkg.sv =====
// shared types and constants of the earliest multi-pattern match block
package emm_pkg;

	localparam int PATTERN_REGS   = 4;
	localparam int WORD_BITS      = 64;
	localparam int LEN_BITS       = 4;
	localparam int LENGTHS_BITS   = PATTERN_REGS * LEN_BITS;
	localparam int ACTIVE_BITS    = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int RESULT_OFFSET_BITS = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_0  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_1  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_2  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_3  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTHS = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE  = 3'd5;

	typedef struct packed {
		logic [PATTERN_REGS-1:0][WORD_BITS-1:0] words;
		logic [LENGTHS_BITS-1:0]                lengths;
		logic [ACTIVE_BITS-1:0]                 active;
	} cfg_t;

endpackage

// ===== hw/rtl/emm_cfg_regs.sv =====
// configuration register file: pattern words, lengths and active count
module emm_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [emm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [emm_pkg::WORD_BITS-1:0]      cfg_data,
	output emm_pkg::cfg_t                      cfg
);
	import emm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WORD_0:  cfg_q.words[0] <= cfg_data;
				REG_WORD_1:  cfg_q.words[1] <= cfg_data;
				REG_WORD_2:  cfg_q.words[2] <= cfg_data;
				REG_WORD_3:  cfg_q.words[3] <= cfg_data;
				REG_LENGTHS: cfg_q.lengths  <= cfg_data[LENGTHS_BITS-1:0];
				REG_ACTIVE:  cfg_q.active   <= cfg_data[ACTIVE_BITS-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/emm_match.sv =====
// parallel window compare against every active pattern and earliest-start select
module emm_match #(
	parameter int NUM_PATTERNS      = 4,
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int OFFSET_BITS       = 16
) (
	input  emm_pkg::cfg_t                  cfg,
	input  logic [MAX_PATTERN_BYTES*8-1:0] cur,
	input  logic [OFFSET_BITS-1:0]         pos,
	input  logic                           best_valid,
	input  logic [OFFSET_BITS-1:0]         best_start,
	output logic                           best_valid_nx,
	output logic [OFFSET_BITS-1:0]         best_start_nx
);
	import emm_pkg::*;

	localparam int EFF_PATTERNS = (NUM_PATTERNS < PATTERN_REGS) ? NUM_PATTERNS : PATTERN_REGS;

	always_comb begin
		logic [LEN_BITS-1:0]    len;
		logic [LEN_BITS-1:0]    len_m1;
		logic                   hit;
		logic                   cand_ok;
		logic [OFFSET_BITS-1:0] cand;
		logic [7:0]             pb;
		best_valid_nx = best_valid;
		best_start_nx = best_start;
		for (int p = 0; p < EFF_PATTERNS; p++) begin
			len     = cfg.lengths[p*LEN_BITS +: LEN_BITS];
			len_m1  = len - LEN_BITS'(1);
			hit     = 1'b0;
			pb      = '0;
			cand_ok = 1'b0;
			cand    = '0;
			if (cfg.active > ACTIVE_BITS'(p)) begin
				if (len == '0) begin
					// empty pattern matches at the message start
					cand_ok = 1'b1;
				end else if (len <= LEN_BITS'(MAX_PATTERN_BYTES) &&
						pos >= OFFSET_BITS'(len_m1)) begin
					hit = 1'b1;
					for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
						pb = cfg.words[p][8*j +: 8];
						// pattern byte j lines up with window byte len-1-j
						for (int k = 0; k + j < MAX_PATTERN_BYTES; k++) begin
							if (len_m1 == LEN_BITS'(j + k) && pb != cur[8*k +: 8])
								hit = 1'b0;
						end
					end
					cand_ok = hit;
					cand    = pos - OFFSET_BITS'(len_m1);
				end
			end
			if (cand_ok && (!best_valid_nx || cand < best_start_nx)) begin
				best_valid_nx = 1'b1;
				best_start_nx = cand;
			end
		end
	end

endmodule

// ===== hw/rtl/earliest_multi_pattern_match_top.sv =====
// top level of the earliest multi-pattern match block
//
// usage: load up to four patterns over the cfg channel (index 0..3 pattern
// words, 4 packed 4-bit lengths, 5 active pattern count) while the block is
// idle, then stream message bytes on the in channel, one transfer per byte,
// with final_byte set on the last byte of each message.
// each final byte yields exactly one transfer on the out channel carrying
// found, the earliest match start offset and the offset overflow flag.
// throughput: one byte per cycle while no final byte waits for the result
// register, set by the update loop of the byte window, position counter and best-start register.
// path: a byte is captured in the input register and is processed from it;
// a final byte's result is loaded into the result register when that byte is
// processed, and out_valid then stays high until the result transfers.
// stall: the result register holds while out_ready is low; non-final bytes
// keep flowing, and a final byte waits in the input register until the
// result register is free, with in_ready low while it waits.
// reset: arst_n clears configuration, message state and both valid flags.
module earliest_multi_pattern_match_top #(
	parameter int NUM_PATTERNS      = 4,
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int OFFSET_BITS       = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [emm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [emm_pkg::WORD_BITS-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           haystack_byte,
	input  logic                                 final_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [emm_pkg::RESULT_OFFSET_BITS-1:0] match_offset,
	output logic                                 offset_overflow
);
	import emm_pkg::*;

	localparam int CUR_W = MAX_PATTERN_BYTES * 8;
	localparam int WIN_W = (MAX_PATTERN_BYTES > 1) ? (MAX_PATTERN_BYTES - 1) * 8 : 8;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	cfg_t cfg;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// message state
	logic [WIN_W-1:0]       window_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] best_start_q;
	logic                   best_valid_q;
	logic                   ovf_q;

	// result register
	logic                          out_valid_q;
	logic                          found_q;
	logic [RESULT_OFFSET_BITS-1:0] offset_q;
	logic                          ovf_out_q;

	logic                   slot_free;
	logic                   proc;
	logic [CUR_W-1:0]       cur;
	logic [WIN_W-1:0]       window_nx;
	logic                   ov_now;
	logic                   best_valid_nx;
	logic [OFFSET_BITS-1:0] best_start_nx;

	emm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a final byte needs the result register, other bytes never wait
	assign slot_free = !out_valid_q || out_ready;
	assign proc      = valid_s1 && (!final_s1 || slot_free);
	assign in_ready  = !valid_s1 || proc;

	// newest byte low, older window bytes above it
	generate
		if (MAX_PATTERN_BYTES > 1) begin : g_win
			assign cur       = {window_q[WIN_W-1:0], byte_s1};
			assign window_nx = cur[WIN_W-1:0];
		end else begin : g_nowin
			assign cur       = byte_s1;
			assign window_nx = '0;
		end
	endgenerate

	// saturated counter: this byte and all later ones reuse the top index
	assign ov_now = (pos_q == POS_MAX);

	emm_match #(
		.NUM_PATTERNS      (NUM_PATTERNS),
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_match (
		.cfg           (cfg),
		.cur           (cur),
		.pos           (pos_q),
		.best_valid    (best_valid_q),
		.best_start    (best_start_q),
		.best_valid_nx (best_valid_nx),
		.best_start_nx (best_start_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= haystack_byte;
			final_s1 <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			pos_q        <= '0;
			best_start_q <= '0;
			best_valid_q <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (proc) begin
			if (final_s1) begin
				// message done, start clean for the next one
				window_q     <= '0;
				pos_q        <= '0;
				best_start_q <= '0;
				best_valid_q <= 1'b0;
				ovf_q        <= 1'b0;
			end else begin
				window_q     <= window_nx;
				pos_q        <= ov_now ? pos_q : pos_q + OFFSET_BITS'(1);
				best_start_q <= best_start_nx;
				best_valid_q <= best_valid_nx;
				ovf_q        <= ovf_q || ov_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && final_s1) begin
			found_q   <= best_valid_nx;
			offset_q  <= best_valid_nx ? RESULT_OFFSET_BITS'(best_start_nx) : '0;
			ovf_out_q <= ovf_q || ov_now;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign match_offset    = offset_q;
	assign offset_overflow = ovf_out_q;

endmodule

// ===== hw/rtl/emm_checker.sv =====
// port-level checker for the earliest multi-pattern match block, with bind
module emm_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic                                   found,
	input logic [emm_pkg::RESULT_OFFSET_BITS-1:0] match_offset,
	input logic                                   offset_overflow
);
	import emm_pkg::*;

	// stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
			$stable(match_offset) && $stable(offset_overflow))
		else $error("result changed while stalled");

	// no match means a zero offset
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0)
		else $error("offset nonzero without a match");

	// a receiver that takes results never blocks the byte stream
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is free");

endmodule

bind earliest_multi_pattern_match_top emm_checker u_emm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.found           (found),
	.match_offset    (match_offset),
	.offset_overflow (offset_overflow)
);
